// ===== hw/rtl/dcwm_pkg.sv =====
// Shared constants for the dual channel windowed mean block.
package dcwm_pkg;

   // Sample, window/count and lookback field widths
   localparam int DATA_W = 24;
   localparam int WIN_W  = 10;
   localparam int LB_W   = 9;

   // Default ring depth and window register reset value
   localparam int             HISTORY_DEPTH_DEF = 512;
   localparam logic [WIN_W-1:0] WINDOW_RESET    = 10'd300;

endpackage

// ===== hw/rtl/dual_channel_windowed_mean_top.sv =====
// Top level of the dual channel windowed mean block.
// Each item writes one main and one plant sample into a shared ring of HISTORY_DEPTH
// slots and returns both channels' means over the newest min(window_length, stored
// count) samples (a window_length of 0 counts as 1), the two samples lookback places
// before the newest (zero where the slot was never written since reset), and the count
// averaged. The block takes one item at a time; req_ready is high only while idle. An
// item reads the ring once per cycle through the two history RAMs for the N samples it
// averages, then runs the serial divider of width SUM_W = 24 + clog2(DEPTH + 1) once per
// channel (one quotient bit per cycle). Before that, L = lookback / HISTORY_DEPTH subtract
// steps bring the lookback into ring range (zero for the default depth of 512). No
// clearing pass is needed after reset: the fill count marks which slots hold samples. A
// finished result is held in the output register, so a new item may be taken while it
// waits for rsp_ready.
module dual_channel_windowed_mean_top #(
   parameter int HISTORY_DEPTH = dcwm_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic        [dcwm_pkg::WIN_W-1:0]   csr_wr_data,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dcwm_pkg::DATA_W-1:0]  req_main_power,
   input  logic signed [dcwm_pkg::DATA_W-1:0]  req_plant_power,
   input  logic        [dcwm_pkg::LB_W-1:0]    req_lookback,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dcwm_pkg::DATA_W-1:0]  rsp_main_mean,
   output logic signed [dcwm_pkg::DATA_W-1:0]  rsp_plant_mean,
   output logic signed [dcwm_pkg::DATA_W-1:0]  rsp_main_past,
   output logic signed [dcwm_pkg::DATA_W-1:0]  rsp_plant_past,
   output logic        [dcwm_pkg::WIN_W-1:0]   rsp_averaged_count
);

   localparam int DW    = dcwm_pkg::DATA_W;
   localparam int WW    = dcwm_pkg::WIN_W;
   localparam int LW    = dcwm_pkg::LB_W;
   localparam int AW    = $clog2(HISTORY_DEPTH);
   localparam int CW    = $clog2(HISTORY_DEPTH + 1);
   localparam int IXW   = AW + 1;
   localparam int LBX_W = (LW > IXW) ? LW : IXW;
   localparam int MW    = (WW > CW) ? WW : CW;
   localparam int SUM_W = DW + CW;

   localparam logic [CW-1:0]    DEPTH_C  = CW'(HISTORY_DEPTH);
   localparam logic [LBX_W-1:0] DEPTH_X  = LBX_W'(HISTORY_DEPTH);
   localparam logic [AW-1:0]    LAST_IDX = AW'(HISTORY_DEPTH - 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LBMOD = 4'd1;
   localparam logic [3:0] S_PAST  = 4'd2;
   localparam logic [3:0] S_PCAP  = 4'd3;
   localparam logic [3:0] S_ACCUM = 4'd4;
   localparam logic [3:0] S_DIVM  = 4'd5;
   localparam logic [3:0] S_WM    = 4'd6;
   localparam logic [3:0] S_DIVP  = 4'd7;
   localparam logic [3:0] S_WP    = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // Control registers
   logic [3:0]    state_ff, state_in;
   logic [WW-1:0] window_ff, window_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] stored_ff, stored_in;
   logic          dv_ff, dv_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [AW-1:0]           newest_ff, newest_in;
   logic [LBX_W-1:0]        lb_ff, lb_in;
   logic [AW-1:0]           past_idx_ff, past_idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           rd_idx_ff, rd_idx_in;
   logic [CW-1:0]           iss_ff, iss_in;
   logic                    written_ff, written_in;
   logic signed [SUM_W-1:0] sum_main_ff, sum_main_in;
   logic signed [SUM_W-1:0] sum_plant_ff, sum_plant_in;
   logic signed [DW-1:0]    main_past_ff, main_past_in;
   logic signed [DW-1:0]    plant_past_ff, plant_past_in;
   logic signed [DW-1:0]    main_mean_ff, main_mean_in;
   logic signed [DW-1:0]    plant_mean_ff, plant_mean_in;

   // Output registers
   logic signed [DW-1:0] rsp_main_mean_ff, rsp_main_mean_in;
   logic signed [DW-1:0] rsp_plant_mean_ff, rsp_plant_mean_in;
   logic signed [DW-1:0] rsp_main_past_ff, rsp_main_past_in;
   logic signed [DW-1:0] rsp_plant_past_ff, rsp_plant_past_in;
   logic [WW-1:0]        rsp_count_ff, rsp_count_in;

   // RAM and divider hookup
   logic                    ram_we;
   logic [AW-1:0]           rd_addr;
   logic signed [DW-1:0]    rd_main;
   logic signed [DW-1:0]    rd_plant;
   logic                    div_start;
   logic signed [SUM_W-1:0] div_dividend;
   logic                    div_done;
   logic signed [DW-1:0]    div_quotient;

   // Helpers for window and lookback math
   logic [WW-1:0]    win_eff;
   logic [LBX_W-1:0] newest_x;
   logic [LBX_W-1:0] past_x;

   dcwm_ram #(.WIDTH(DW), .DEPTH(HISTORY_DEPTH)) u_main_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_main_power),
      .rd_addr (rd_addr),
      .rd_data (rd_main)
   );

   dcwm_ram #(.WIDTH(DW), .DEPTH(HISTORY_DEPTH)) u_plant_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_plant_power),
      .rd_addr (rd_addr),
      .rd_data (rd_plant)
   );

   dcwm_div #(.SUM_W(SUM_W), .DEN_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign win_eff      = (window_ff == '0) ? WW'(1) : window_ff;
   assign newest_x     = LBX_W'(newest_ff);
   assign past_x       = (newest_x >= lb_ff) ? (newest_x - lb_ff)
                                             : (newest_x + DEPTH_X - lb_ff);
   assign div_dividend = (state_ff == S_DIVP) ? sum_plant_ff : sum_main_ff;

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      window_in         = csr_wr_en ? csr_wr_data : window_ff;
      wp_in             = wp_ff;
      stored_in         = stored_ff;
      dv_in             = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      newest_in         = newest_ff;
      lb_in             = lb_ff;
      past_idx_in       = past_idx_ff;
      count_in          = count_ff;
      rd_idx_in         = rd_idx_ff;
      iss_in            = iss_ff;
      written_in        = written_ff;
      sum_main_in       = sum_main_ff;
      sum_plant_in      = sum_plant_ff;
      main_past_in      = main_past_ff;
      plant_past_in     = plant_past_ff;
      main_mean_in      = main_mean_ff;
      plant_mean_in     = plant_mean_ff;
      rsp_main_mean_in  = rsp_main_mean_ff;
      rsp_plant_mean_in = rsp_plant_mean_ff;
      rsp_main_past_in  = rsp_main_past_ff;
      rsp_plant_past_in = rsp_plant_past_ff;
      rsp_count_in      = rsp_count_ff;
      ram_we            = 1'b0;
      rd_addr           = rd_idx_ff;
      div_start         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // write both samples and advance the ring
            if (req_valid) begin
               ram_we    = 1'b1;
               newest_in = wp_ff;
               wp_in     = (wp_ff == LAST_IDX) ? '0 : wp_ff + AW'(1);
               if (stored_ff != DEPTH_C) begin
                  stored_in = stored_ff + CW'(1);
               end
               lb_in    = LBX_W'(req_lookback);
               state_in = S_LBMOD;
            end
         end
         S_LBMOD: begin
            // bring lookback into ring range, then set up the window walk
            if (lb_ff >= DEPTH_X) begin
               lb_in = lb_ff - DEPTH_X;
            end else begin
               past_idx_in  = AW'(past_x);
               count_in     = (MW'(win_eff) < MW'(stored_ff)) ? CW'(win_eff) : stored_ff;
               rd_idx_in    = newest_ff;
               iss_in       = '0;
               sum_main_in  = '0;
               sum_plant_in = '0;
               state_in     = S_PAST;
            end
         end
         S_PAST: begin
            rd_addr    = past_idx_ff;
            written_in = (stored_ff == DEPTH_C) || (IXW'(past_idx_ff) < IXW'(stored_ff));
            state_in   = S_PCAP;
         end
         S_PCAP: begin
            // slots never written since reset read as zero
            main_past_in  = written_ff ? rd_main : '0;
            plant_past_in = written_ff ? rd_plant : '0;
            state_in      = S_ACCUM;
         end
         S_ACCUM: begin
            // issue one read per cycle, add the one that came back
            if (iss_ff != count_ff) begin
               dv_in     = 1'b1;
               iss_in    = iss_ff + CW'(1);
               rd_idx_in = (rd_idx_ff == '0) ? LAST_IDX : rd_idx_ff - AW'(1);
            end
            if (dv_ff) begin
               sum_main_in  = sum_main_ff + SUM_W'(rd_main);
               sum_plant_in = sum_plant_ff + SUM_W'(rd_plant);
            end
            if ((iss_ff == count_ff) && !dv_ff) begin
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            div_start = 1'b1;
            state_in  = S_WM;
         end
         S_WM: begin
            if (div_done) begin
               main_mean_in = div_quotient;
               state_in     = S_DIVP;
            end
         end
         S_DIVP: begin
            div_start = 1'b1;
            state_in  = S_WP;
         end
         S_WP: begin
            if (div_done) begin
               plant_mean_in = div_quotient;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_main_mean_in  = main_mean_ff;
               rsp_plant_mean_in = plant_mean_ff;
               rsp_main_past_in  = main_past_ff;
               rsp_plant_past_in = plant_past_ff;
               rsp_count_in      = WW'(count_ff);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= dcwm_pkg::WINDOW_RESET;
         wp_ff        <= '0;
         stored_ff    <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wp_ff        <= wp_in;
         stored_ff    <= stored_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff         <= newest_in;
      lb_ff             <= lb_in;
      past_idx_ff       <= past_idx_in;
      count_ff          <= count_in;
      rd_idx_ff         <= rd_idx_in;
      iss_ff            <= iss_in;
      written_ff        <= written_in;
      sum_main_ff       <= sum_main_in;
      sum_plant_ff      <= sum_plant_in;
      main_past_ff      <= main_past_in;
      plant_past_ff     <= plant_past_in;
      main_mean_ff      <= main_mean_in;
      plant_mean_ff     <= plant_mean_in;
      rsp_main_mean_ff  <= rsp_main_mean_in;
      rsp_plant_mean_ff <= rsp_plant_mean_in;
      rsp_main_past_ff  <= rsp_main_past_in;
      rsp_plant_past_ff <= rsp_plant_past_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_main_mean      = rsp_main_mean_ff;
   assign rsp_plant_mean     = rsp_plant_mean_ff;
   assign rsp_main_past      = rsp_main_past_ff;
   assign rsp_plant_past     = rsp_plant_past_ff;
   assign rsp_averaged_count = rsp_count_ff;

   // Fill count never passes the ring depth
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= DEPTH_C)
      else $error("stored count beyond ring depth");

   // An accepted item always starts the lookback reduction
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_LBMOD)
      else $error("accepted item did not start processing");

   // The window walk covers at least one stored sample
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACCUM |-> (count_ff != '0) && (count_ff <= stored_ff))
      else $error("averaged count out of range");

   // Divider results arrive only while the sequencer waits for them
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WM) || (state_ff == S_WP))
      else $error("divider finished outside a wait state");

   // A result appears only from the hand-over state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside hand-over");

endmodule

// ===== hw/rtl/dcwm_ram.sv =====
// Generic simple dual port RAM with one write port and one registered read port.
module dcwm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dcwm_div.sv =====
// Serial restoring divider: signed sum by unsigned count, truncating toward zero.
module dcwm_div #(
   parameter int SUM_W = 34,
   parameter int DEN_W = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             dividend,
   input  logic        [DEN_W-1:0]             divisor,
   output logic                                done,
   output logic signed [dcwm_pkg::DATA_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam int DW    = dcwm_pkg::DATA_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [DEN_W:0]   trial;
   logic             take;

   // One quotient bit per cycle, most significant first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, mag_ff[SUM_W-1]};
      take    = (trial >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         mag_in = {mag_ff[SUM_W-2:0], 1'b0};
         quo_in = {quo_ff[SUM_W-2:0], take};
         rem_in = take ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Sign fix on the low bits only; the mean always fits the sample width
   assign done     = done_ff;
   assign quotient = neg_ff ? DW'(-quo_ff[DW-1:0]) : quo_ff[DW-1:0];

endmodule
